// File: design/ssag_pkg.sv
// ----------------------------------------------------------------------------
// ssag_pkg
// Shared types and constants of the spiral scan address generator.
// ----------------------------------------------------------------------------
package ssag_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_GRID_ROWS  = 2'd0;
	localparam logic [1:0] REG_GRID_COLS  = 2'd1;
	localparam logic [1:0] REG_ORIGIN_ROW = 2'd2;
	localparam logic [1:0] REG_ORIGIN_COL = 2'd3;

	// Depth of the command queue between the front and the walker.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	typedef enum logic {
		CMD_NEXT,
		CMD_RESTART
	} cmd_t;

	typedef enum logic [1:0] {
		HEAD_EAST,
		HEAD_SOUTH,
		HEAD_WEST,
		HEAD_NORTH
	} heading_t;

	// Head of the command queue as seen by the walker.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_word_t;

	// Configuration registers as the walker samples them at a restart.
	typedef struct packed {
		logic [7:0] grid_rows;
		logic [7:0] grid_cols;
		logic [6:0] origin_row;
		logic [6:0] origin_col;
	} cfg_t;

endpackage

// File: design/ssag_req_if.sv
// ----------------------------------------------------------------------------
// ssag_req_if
// Request channel: one word per request, carrying the restart flag.
// ----------------------------------------------------------------------------
interface ssag_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// File: design/ssag_res_if.sv
// ----------------------------------------------------------------------------
// ssag_res_if
// Result channel: one word per request, carrying the emitted grid cell.
// ----------------------------------------------------------------------------
interface ssag_res_if;
	logic       valid;
	logic       ready;
	logic [6:0] cell_row;
	logic [6:0] cell_col;
	logic       is_last;
	logic       valid_res;

	modport source (output valid, output cell_row, output cell_col, output is_last,
		output valid_res, input ready);
	modport sink (input valid, input cell_row, input cell_col, input is_last,
		input valid_res, output ready);
endinterface

// File: design/spiral_scan_address_generator.sv
// ----------------------------------------------------------------------------
// spiral_scan_address_generator
// Emits grid cells in outward clockwise spiral order from a start cell.
// ----------------------------------------------------------------------------
// Usage: write grid_rows, grid_cols, origin_row and origin_col through the
// cfg port while the block is idle. Each word on the req channel asks for one
// result word on the res channel: restart=1 begins a new walk and returns the
// start cell, restart=0 returns the next in-grid cell of the walk. is_last
// marks the final cell; once the walk is over, or before any walk, a request
// returns a word with valid_res=0.
// Timing: each request word is registered in the command queue. The walker
// pops it in the wait state; a restart, or a next-cell request with no walk
// going, loads the result register directly, while a next-cell request of a
// walk enters the search state, which tests one spiral position per cycle
// and loads the result word on reaching an in-grid cell. The walker pops a
// new command only once it is back in the wait state and the result register
// is free or being read, so the walker never works on two commands at once.
// Reset clears the walk (idle), the queue and the output register, and sets
// the registers to a one-by-one grid with the origin at cell (0, 0).
// A stalled receiver holds the result word; up to two further requests wait
// in the command queue, after which req.ready drops.
// ----------------------------------------------------------------------------
module spiral_scan_address_generator #(
	parameter int MAX_DIM = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	ssag_req_if.sink    req,
	ssag_res_if.source  res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	ssag_pkg::cfg_t       cfg_q;
	ssag_pkg::cmd_word_t  cmd;
	logic                 pop;

	// Configuration registers. They are sampled by the walker only when a
	// restart command is carried out, so a walk keeps its own grid size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_rows  <= 8'd1;
			cfg_q.grid_cols  <= 8'd1;
			cfg_q.origin_row <= 7'd0;
			cfg_q.origin_col <= 7'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				ssag_pkg::REG_GRID_ROWS:  cfg_q.grid_rows  <= cfg_data;
				ssag_pkg::REG_GRID_COLS:  cfg_q.grid_cols  <= cfg_data;
				ssag_pkg::REG_ORIGIN_ROW: cfg_q.origin_row <= cfg_data[6:0];
				ssag_pkg::REG_ORIGIN_COL: cfg_q.origin_col <= cfg_data[6:0];
				default:                  cfg_q            <= cfg_q;
			endcase
		end
	end

	// Front: takes request words and queues them as commands.
	ssag_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.cmd    (cmd)
	);

	// Back: walks the spiral and owns the result register.
	ssag_walker #(
		.MAX_DIM (MAX_DIM)
	) u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pop    (pop),
		.cfg    (cfg_q),
		.res    (res)
	);

endmodule

// File: design/ssag_front.sv
// ----------------------------------------------------------------------------
// ssag_front
// Accepts request words, classifies them as restart or next-cell commands
// and holds them in a short queue for the walker.
// ----------------------------------------------------------------------------
module ssag_front (
	input  logic                   clk,
	input  logic                   arst_n,
	ssag_req_if.sink               req,
	input  logic                   pop,
	output ssag_pkg::cmd_word_t    cmd
);

	ssag_pkg::cmd_t                  queue_q [ssag_pkg::QUEUE_DEPTH];
	logic [ssag_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [ssag_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [ssag_pkg::QUEUE_AW:0]     count_q;
	logic                            push;
	logic                            take;
	ssag_pkg::cmd_t                  cmd_in;

	assign req.ready = (count_q != (ssag_pkg::QUEUE_AW + 1)'(ssag_pkg::QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign take      = pop && (count_q != '0);
	assign cmd_in    = req.restart ? ssag_pkg::CMD_RESTART : ssag_pkg::CMD_NEXT;

	assign cmd.valid = (count_q != '0);
	assign cmd.cmd   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, take})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/ssag_walker.sv
// ----------------------------------------------------------------------------
// ssag_walker
// Carries out queued commands: walks the spiral one position per cycle and
// registers each result word for the output channel.
// ----------------------------------------------------------------------------
module ssag_walker #(
	parameter int MAX_DIM = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssag_pkg::cmd_word_t  cmd,
	output logic                 pop,
	input  ssag_pkg::cfg_t       cfg,
	ssag_res_if.source           res
);

	// Grid sizes clamp to MAX_DIM, which is itself capped at the register maximum of 255.
	localparam int EFF = (MAX_DIM < 255) ? MAX_DIM : 255;
	localparam int DW  = $clog2(EFF + 1);
	localparam int CW  = DW + 2;
	localparam int NW  = $clog2(EFF * EFF + 1);

	typedef enum logic {
		ST_WAIT,
		ST_SEARCH
	} state_t;

	state_t                 state_q;
	logic                   res_valid_q;
	logic [6:0]             res_row_q;
	logic [6:0]             res_col_q;
	logic                   res_last_q;
	logic                   res_flag_q;

	logic signed [CW-1:0]   row_q;
	logic signed [CW-1:0]   col_q;
	ssag_pkg::heading_t     heading_q;
	logic [CW-1:0]          len_q;
	logic [CW-1:0]          prog_q;
	logic [NW-1:0]          cnt_q;
	logic                   active_q;
	logic [DW-1:0]          rows_q;
	logic [DW-1:0]          cols_q;
	logic [NW-1:0]          target_q;

	logic                   out_free;
	logic                   res_load;
	logic [7:0]             rows_c;
	logic [7:0]             cols_c;
	logic [2*DW-1:0]        area;
	logic                   origin_in;
	logic                   single;
	logic signed [CW-1:0]   step_row;
	logic signed [CW-1:0]   step_col;
	logic [CW-1:0]          prog_inc;
	logic                   leg_done;
	logic [CW-1:0]          nxt_prog;
	logic [CW-1:0]          nxt_len;
	ssag_pkg::heading_t     nxt_heading;
	logic                   step_in;
	logic [NW-1:0]          cnt_inc;
	logic                   step_last;

	assign res.valid     = res_valid_q;
	assign res.cell_row  = res_row_q;
	assign res.cell_col  = res_col_q;
	assign res.is_last   = res_last_q;
	assign res.valid_res = res_flag_q;

	assign out_free = !res_valid_q || res.ready;
	assign pop      = (state_q == ST_WAIT) && cmd.valid && out_free;

	// A result word is loaded by a restart, by a request while idle, and by
	// the search step that lands on an in-grid cell.
	assign res_load = (pop && ((cmd.cmd == ssag_pkg::CMD_RESTART) || !active_q))
		|| ((state_q == ST_SEARCH) && step_in);

	assign rows_c    = (cfg.grid_rows > 8'(EFF)) ? 8'(EFF) : cfg.grid_rows;
	assign cols_c    = (cfg.grid_cols > 8'(EFF)) ? 8'(EFF) : cfg.grid_cols;
	assign area      = rows_c[DW-1:0] * cols_c[DW-1:0];
	assign origin_in = ({1'b0, cfg.origin_row} < rows_c) && ({1'b0, cfg.origin_col} < cols_c);
	assign single    = (rows_c == 8'd1) && (cols_c == 8'd1);

	always_comb begin
		step_row = row_q;
		step_col = col_q;
		case (heading_q)
			ssag_pkg::HEAD_EAST:  step_col = col_q + CW'(1);
			ssag_pkg::HEAD_SOUTH: step_row = row_q + CW'(1);
			ssag_pkg::HEAD_WEST:  step_col = col_q - CW'(1);
			default:              step_row = row_q - CW'(1);
		endcase
	end

	assign prog_inc    = prog_q + CW'(1);
	assign leg_done    = (prog_inc >= len_q);
	assign nxt_prog    = leg_done ? '0 : prog_inc;
	assign nxt_len     = (leg_done && heading_q[0]) ? len_q + CW'(1) : len_q;
	assign nxt_heading = leg_done ? ssag_pkg::heading_t'(heading_q + 2'd1) : heading_q;

	assign step_in = !step_row[CW-1] && !step_col[CW-1]
		&& ($unsigned(step_row) < {2'b00, rows_q})
		&& ($unsigned(step_col) < {2'b00, cols_q});
	assign cnt_inc   = cnt_q + NW'(1);
	assign step_last = (cnt_inc >= target_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WAIT;
			res_valid_q <= 1'b0;
			res_row_q   <= '0;
			res_col_q   <= '0;
			res_last_q  <= 1'b0;
			res_flag_q  <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			heading_q   <= ssag_pkg::HEAD_EAST;
			len_q       <= CW'(1);
			prog_q      <= '0;
			cnt_q       <= '0;
			active_q    <= 1'b0;
			rows_q      <= '0;
			cols_q      <= '0;
			target_q    <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_WAIT: begin
					if (pop) begin
						if (cmd.cmd == ssag_pkg::CMD_RESTART) begin
							rows_q      <= rows_c[DW-1:0];
							cols_q      <= cols_c[DW-1:0];
							target_q    <= NW'(area);
							row_q       <= CW'(cfg.origin_row);
							col_q       <= CW'(cfg.origin_col);
							heading_q   <= ssag_pkg::HEAD_EAST;
							len_q       <= CW'(1);
							prog_q      <= '0;
							if (origin_in) begin
								cnt_q      <= NW'(1);
								active_q   <= !single;
								res_row_q  <= cfg.origin_row;
								res_col_q  <= cfg.origin_col;
								res_last_q <= single;
								res_flag_q <= 1'b1;
							end else begin
								cnt_q      <= '0;
								active_q   <= 1'b0;
								res_row_q  <= '0;
								res_col_q  <= '0;
								res_last_q <= 1'b0;
								res_flag_q <= 1'b0;
							end
						end else if (active_q) begin
							state_q <= ST_SEARCH;
						end else begin
							res_row_q   <= '0;
							res_col_q   <= '0;
							res_last_q  <= 1'b0;
							res_flag_q  <= 1'b0;
						end
					end
				end
				ST_SEARCH: begin
					row_q     <= step_row;
					col_q     <= step_col;
					prog_q    <= nxt_prog;
					len_q     <= nxt_len;
					heading_q <= nxt_heading;
					if (step_in) begin
						cnt_q       <= cnt_inc;
						active_q    <= !step_last;
						res_row_q   <= 7'(step_row);
						res_col_q   <= 7'(step_col);
						res_last_q  <= step_last;
						res_flag_q  <= 1'b1;
						state_q     <= ST_WAIT;
					end
				end
				default: state_q <= ST_WAIT;
			endcase
		end
	end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the spiral scan address generator. A
// predictor of the outward clockwise spiral walk produces the expected cell
// word for every accepted request, and a monitor compares each result word
// field by field. Directed grids cover the corner cases, then randomized
// grids and request sequences run under several sender and receiver idling
// patterns.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM       = 128;
	localparam int ITEM_TARGET   = 950;
	localparam int STALL_LIMIT   = 20000;
	localparam int REPORT_LIMIT  = 10;
	localparam int SETTLE_CYCLES = 20;

	// One result word as the predictor sees it.
	typedef struct packed {
		logic [6:0] cell_row;
		logic [6:0] cell_col;
		logic       is_last;
		logic       valid_res;
	} cell_word_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	ssag_req_if req_ch ();
	ssag_res_if res_ch ();

	spiral_scan_address_generator #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Free-running 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Restart flags waiting to be offered, and cell words waiting to come back.
	logic       requests_pending[$];
	cell_word_t cells_due[$];

	// Idling pattern of the current phase, in percent of cycles.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	int mismatches   = 0;
	int queued_items = 0;
	int quiet_cycles = 0;

	// Predictor state. The register copy starts at the reset values of the
	// block; the walk starts idle with no grid latched.
	ssag_pkg::cfg_t     shadow     = '{grid_rows: 8'd1, grid_cols: 8'd1,
		origin_row: 7'd0, origin_col: 7'd0};
	int                 lat_rows   = 0;
	int                 lat_cols   = 0;
	int                 pos_row    = 0;
	int                 pos_col    = 0;
	ssag_pkg::heading_t dir        = ssag_pkg::HEAD_EAST;
	int                 leg_len    = 1;
	int                 leg_step   = 0;
	int                 cell_count = 0;
	bit                 walking    = 1'b0;

	// Grid sizes above the parameter limit behave as the limit itself.
	function automatic int clip_dim(input int v);
		return (v > MAX_DIM) ? MAX_DIM : v;
	endfunction

	function automatic bit on_grid(input int r, input int c);
		return r >= 0 && c >= 0 && r < lat_rows && c < lat_cols;
	endfunction

	// Moves one position along the spiral. Every second leg, that is after
	// each south and each north leg, the leg length grows by one.
	task automatic step_spiral();
		case (dir)
			ssag_pkg::HEAD_EAST: begin
				pos_col++;
			end
			ssag_pkg::HEAD_SOUTH: begin
				pos_row++;
			end
			ssag_pkg::HEAD_WEST: begin
				pos_col--;
			end
			default: begin
				pos_row--;
			end
		endcase
		leg_step++;
		if (leg_step >= leg_len) begin
			leg_step = 0;
			if (dir == ssag_pkg::HEAD_SOUTH || dir == ssag_pkg::HEAD_NORTH) begin
				leg_len++;
			end
			dir = dir.next();
		end
	endtask

	// Works out the cell word that one accepted request must produce and
	// advances the walk. A word with valid_res low has all other fields zero.
	task automatic predict_cell(input logic restart, output cell_word_t w);
		int target;
		w = '0;
		if (restart) begin
			// A restart latches the grid size; later register writes only matter
			// at the following restart.
			lat_rows   = clip_dim(int'(shadow.grid_rows));
			lat_cols   = clip_dim(int'(shadow.grid_cols));
			pos_row    = int'(shadow.origin_row);
			pos_col    = int'(shadow.origin_col);
			dir        = ssag_pkg::HEAD_EAST;
			leg_len    = 1;
			leg_step   = 0;
			cell_count = 0;
			walking    = 1'b0;
			// An empty grid or a start cell off the grid leaves the walk idle.
			if (on_grid(pos_row, pos_col)) begin
				target      = lat_rows * lat_cols;
				cell_count  = 1;
				walking     = (cell_count < target);
				w.cell_row  = 7'(pos_row);
				w.cell_col  = 7'(pos_col);
				w.is_last   = !walking;
				w.valid_res = 1'b1;
			end
		end else if (walking) begin
			// Off-grid positions are skipped; a cell is always left to find here.
			do begin
				step_spiral();
			end while (!on_grid(pos_row, pos_col));
			target = lat_rows * lat_cols;
			cell_count++;
			if (cell_count >= target) begin
				walking = 1'b0;
			end
			w.cell_row  = 7'(pos_row);
			w.cell_col  = 7'(pos_col);
			w.is_last   = !walking;
			w.valid_res = 1'b1;
		end
	endtask

	// Request driver. A new word is offered only once the previous one has
	// been taken, so valid never drops while a word is waiting.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid   <= 1'b0;
			req_ch.restart <= 1'b0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_ch.valid   <= 1'b1;
				req_ch.restart <= requests_pending.pop_front();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Every accepted request turns into exactly one expected cell word.
	always @(posedge clk) begin
		cell_word_t w;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			predict_cell(req_ch.restart, w);
			cells_due = {cells_due, w};
		end
	end

	// Result monitor: each accepted word is checked against the oldest
	// expectation. A word with nothing expected is a failure as well.
	always @(posedge clk) begin
		cell_word_t w;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (cells_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("unexpected word: row %0d col %0d last %0d valid %0d",
						res_ch.cell_row, res_ch.cell_col, res_ch.is_last,
						res_ch.valid_res);
				end
			end else begin
				w = cells_due.pop_front();
				if (res_ch.cell_row !== w.cell_row || res_ch.cell_col !== w.cell_col ||
						res_ch.is_last !== w.is_last || res_ch.valid_res !== w.valid_res) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display({"mismatch: expected row %0d col %0d last %0d valid %0d,",
							" got row %0d col %0d last %0d valid %0d"},
							w.cell_row, w.cell_col, w.is_last, w.valid_res,
							res_ch.cell_row, res_ch.cell_col, res_ch.is_last,
							res_ch.valid_res);
					end
				end
			end
		end
	end

	// Watchdog: a long stretch without any handshake means the block hung.
	// The longest legitimate gap is one search across the outer rings of a
	// thin or corner-started grid, about a thousand spiral positions.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Writes one register at a rising edge and mirrors it in the predictor.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			ssag_pkg::REG_GRID_ROWS: begin
				shadow.grid_rows = val;
			end
			ssag_pkg::REG_GRID_COLS: begin
				shadow.grid_cols = val;
			end
			ssag_pkg::REG_ORIGIN_ROW: begin
				shadow.origin_row = val[6:0];
			end
			default: begin
				shadow.origin_col = val[6:0];
			end
		endcase
	endtask

	// Programs the whole grid, then returns on a falling edge so that the
	// caller can queue requests without racing the driver.
	task automatic set_grid(input int rows, input int cols, input int orow, input int ocol);
		write_reg(ssag_pkg::REG_GRID_ROWS, 8'(rows));
		write_reg(ssag_pkg::REG_GRID_COLS, 8'(cols));
		write_reg(ssag_pkg::REG_ORIGIN_ROW, 8'(orow));
		write_reg(ssag_pkg::REG_ORIGIN_COL, 8'(ocol));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_request(input logic restart);
		requests_pending = {requests_pending, restart};
		queued_items++;
	endtask

	// A restart followed by next-cell requests. Now and then a next request
	// is replaced by a restart, which cuts the walk short.
	task automatic queue_walk(input int nexts);
		queue_request(1'b1);
		repeat (nexts) begin
			queue_request($urandom_range(99) < 4);
		end
	endtask

	// Returns on a falling edge once every request is accepted and every
	// expected word has come back. The block is idle from then on.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (requests_pending.size() != 0 || req_ch.valid || cells_due.size() != 0);
	endtask

	initial begin
		int phase_no;
		int pick;
		int rows;
		int cols;
		int orow;
		int ocol;
		int span;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = ssag_pkg::REG_GRID_ROWS;
		cfg_data  = 8'd0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, no idling. With the reset registers the grid is a
		// single cell: a next request before any walk returns an empty word,
		// the restart returns the only cell flagged last, and a further next
		// request after the end returns an empty word again.
		queue_request(1'b0);
		queue_request(1'b1);
		queue_request(1'b0);
		wait_drained();

		// Empty grid: zero rows make a restart return an empty word.
		set_grid(0, 1, 0, 0);
		queue_request(1'b1);
		wait_drained();

		// Three by three around the center: every heading and leg growth,
		// the full walk, then one request past the end.
		set_grid(3, 3, 1, 1);
		queue_request(1'b1);
		repeat (9) queue_request(1'b0);
		wait_drained();

		// Start cell below the grid: restart and next both give empty words.
		set_grid(2, 2, 5, 0);
		queue_request(1'b1);
		queue_request(1'b0);
		wait_drained();

		// Oversized dimensions act as the limit; the start cell sits at the
		// far corner, so the top row and column values appear.
		set_grid(255, 200, 127, 127);
		queue_request(1'b1);
		repeat (3) queue_request(1'b0);
		wait_drained();

		// New registers while the big walk is still going: the first next
		// request continues the old walk, the restart picks up the new grid.
		set_grid(1, 128, 0, 127);
		queue_request(1'b0);
		queue_request(1'b1);
		repeat (2) queue_request(1'b0);
		wait_drained();

		// Random part. Each phase reprograms the grid while the block is idle
		// and then runs mostly well-formed walks, with some noise and some
		// large or thin grids whose searches run far outside the grid.
		phase_no = 0;
		while (queued_items < ITEM_TARGET) begin
			case (phase_no % 5)
				1: begin
					send_idle_pct  = 54;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 54;
				end
				3: begin
					send_idle_pct  = 28;
					recv_stall_pct = 28;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			pick = $urandom_range(99);
			if (pick < 65) begin
				// Small grid, walked to the end and up to two requests past it. Sometimes a
				// few next requests first continue the walk left from before.
				rows = $urandom_range(1, 10);
				cols = $urandom_range(1, 10);
				orow = $urandom_range(rows - 1);
				ocol = $urandom_range(cols - 1);
				set_grid(rows, cols, orow, ocol);
				if ($urandom_range(9) == 0) begin
					repeat ($urandom_range(1, 3)) queue_request(1'b0);
				end
				queue_walk(rows * cols - 1 + $urandom_range(0, 2));
			end else if (pick < 78) begin
				// Any register values at all, including empty grids and start
				// cells off the grid, with random requests.
				rows = $urandom_range(0, 255);
				cols = $urandom_range(0, 255);
				orow = $urandom_range(127);
				ocol = $urandom_range(127);
				set_grid(rows, cols, orow, ocol);
				repeat ($urandom_range(1, 6)) queue_request(1'($urandom_range(1)));
			end else if (pick < 90) begin
				// Large grid, only the first rings of the walk.
				case ($urandom_range(2))
					0: rows = MAX_DIM;
					1: rows = $urandom_range(MAX_DIM + 1, 255);
					default: rows = $urandom_range(20, MAX_DIM);
				endcase
				case ($urandom_range(2))
					0: cols = MAX_DIM;
					1: cols = $urandom_range(MAX_DIM + 1, 255);
					default: cols = $urandom_range(20, MAX_DIM);
				endcase
				orow = $urandom_range(clip_dim(rows) - 1);
				ocol = $urandom_range(clip_dim(cols) - 1);
				set_grid(rows, cols, orow, ocol);
				queue_walk($urandom_range(20, 40));
			end else begin
				// Single row or column walked to the end: most spiral positions
				// are off the grid, so most searches are long.
				span = $urandom_range(2, MAX_DIM);
				if ($urandom_range(1)) begin
					rows = 1;
					cols = span;
				end else begin
					rows = span;
					cols = 1;
				end
				orow = $urandom_range(rows - 1);
				ocol = $urandom_range(cols - 1);
				set_grid(rows, cols, orow, ocol);
				queue_walk(span);
			end
			wait_drained();
			phase_no++;
		end

		// Give a stray word time to show up before the verdict.
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/ssag_pkg.sv
design/ssag_req_if.sv
design/ssag_res_if.sv
design/ssag_front.sv
design/ssag_walker.sv
design/spiral_scan_address_generator.sv
tb/sv/tb.sv
